FILE: sv/gwpq_pkg.sv
// ----------------------------------------------------------------------------
// gwpq_pkg
// Shared types, operation codes and the priority compare of the graded work
// priority queue.
// ----------------------------------------------------------------------------
package gwpq_pkg;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // field widths fixed by the item format
  localparam int GRADE_W = 8;
  localparam int SEQ_W   = 32;
  localparam int CNT_W   = 6;

  // first-byte distance beyond which the order wraps round
  localparam int WRAP_LIMIT = 10;

  // reset value of the grade limit
  localparam logic [GRADE_W-1:0] MAX_GRADE_RST = 8'd122;

  // configuration register indexes
  localparam logic REG_MAX_GRADE = 1'b0;

  typedef struct packed {
    logic [GRADE_W-1:0] grade;
    logic [SEQ_W-1:0]   seq;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

  // true when the new entry strictly beats the held entry
  function automatic logic beats(entry_t n, entry_t h);
    logic signed [8:0] d;
    logic              res;
    d = $signed({1'b0, h.seq[31:24]}) - $signed({1'b0, n.seq[31:24]});
    if (n.grade != h.grade) begin
      res = (n.grade < h.grade);
    end else if (d != 9'sd0) begin
      if (d > 9'(WRAP_LIMIT) || d < -9'(WRAP_LIMIT)) begin
        res = (d < 9'sd0);
      end else begin
        res = (d > 9'sd0);
      end
    end else begin
      res = (n.seq[23:0] < h.seq[23:0]);
    end
    return res;
  endfunction

endpackage

FILE: sv/gwpq_if.sv
// ----------------------------------------------------------------------------
// gwpq interfaces
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface gwpq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  in_grade;
  logic [31:0] in_sequence;

  modport source (output valid, operation, in_grade, in_sequence, input ready);
  modport sink   (input valid, operation, in_grade, in_sequence, output ready);
endinterface

interface gwpq_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        evicted;
  logic [7:0]  out_grade;
  logic [31:0] out_sequence;
  logic [5:0]  count;

  modport source (output valid, accepted, evicted, out_grade, out_sequence, count,
                  input ready);
  modport sink   (input valid, accepted, evicted, out_grade, out_sequence, count,
                  output ready);
endinterface

FILE: sv/gwpq_cell.sv
// ----------------------------------------------------------------------------
// gwpq_cell
// One slot of the sorted list: holds an entry, compares it with the new
// entry and shifts with its neighbours on insert and pop.
// ----------------------------------------------------------------------------
module gwpq_cell
  import gwpq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       valid,
  input  entry_t     new_ent,
  input  entry_t     left_ent,
  input  entry_t     right_ent,
  input  logic       left_all,
  input  logic       right_all,
  output logic       all_o,
  output entry_t     ent_o
);

  entry_t ent_r, ent_nxt;

  // new entry beats this slot and every slot to the right
  assign all_o = right_all & (~valid | beats(new_ent, ent_r));
  assign ent_o = ent_r;

  // shift right on insert, left on pop
  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.ins) begin
      if (left_all) begin
        ent_nxt = left_ent;
      end else if (all_o) begin
        ent_nxt = new_ent;
      end
    end else if (ctrl.pop) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

FILE: sv/graded_work_priority_queue_core.sv
// ----------------------------------------------------------------------------
// graded_work_priority_queue_core
// Bounded sorted priority list of work entries built as a row of slots.
//
//   channel   | dir | handshake            | payload
//   ----------+-----+----------------------+--------------------------------
//   in_ch     | in  | valid / ready        | operation, in_grade, in_sequence
//   out_ch    | out | valid / ready        | accepted, evicted, out_grade,
//             |     |                      | out_sequence, count
//   cfg_*     | in  | APB write, pready=1  | max_grade at byte address 0
//
// Each item is executed in the cycle it is accepted: every slot compares
// itself with the new entry at once and the beats flags ripple along the row.
// The result is registered, so one item per cycle while out_ch is taken.
// in_ch.ready drops only while a result waits and out_ch.ready is low.
// Reset empties the list and restores max_grade to 122; slots need no clear.
// ----------------------------------------------------------------------------
module graded_work_priority_queue_core
  import gwpq_pkg::*;
#(
  parameter int CAPACITY = 32
)
(
  input  logic        clk,
  input  logic        rst_n,
  gwpq_in_if.sink     in_ch,
  gwpq_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [GRADE_W-1:0] max_grade_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r;
  logic               acc_r, ev_r;
  logic [GRADE_W-1:0] og_r;
  logic [SEQ_W-1:0]   os_r;
  logic [CW-1:0]      cnt_out_r;

  entry_t             new_ent;
  entry_t             ent_w [CAPACITY];
  logic               all_w [CAPACITY];
  cell_ctrl_t         ctrl;
  logic               fire, full, is_ins, ins_ok, pop_ok, clr;
  logic [CW+CNT_W-1:0] cnt_wide;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_GRADE) ? {24'd0, max_grade_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_grade_r <= MAX_GRADE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_MAX_GRADE) begin
      max_grade_r <= cfg_pwdata[7:0];
    end
  end

  // handshake and decode
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign fire        = in_ch.valid & in_ch.ready;
  assign new_ent     = '{grade: in_ch.in_grade, seq: in_ch.in_sequence};
  assign full        = (count_r == CW'(CAPACITY));
  assign is_ins      = (in_ch.operation == OP_INSERT) && (in_ch.in_grade <= max_grade_r);
  assign ins_ok      = fire & is_ins & all_w[CAPACITY-1];
  assign pop_ok      = fire & (in_ch.operation == OP_POP) & (count_r != '0);
  assign clr         = fire & (in_ch.operation == OP_CLEAR);
  assign ctrl        = '{ins: ins_ok, pop: pop_ok};

  // row of slots
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int L = (i == 0) ? 0 : i - 1;
    localparam int R = (i == CAPACITY - 1) ? i : i + 1;
    gwpq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .valid     (CW'(i) < count_r),
      .new_ent   (new_ent),
      .left_ent  (ent_w[L]),
      .right_ent (ent_w[R]),
      .left_all  ((i == 0) ? 1'b0 : all_w[L]),
      .right_all ((i == CAPACITY - 1) ? 1'b1 : all_w[R]),
      .all_o     (all_w[i]),
      .ent_o     (ent_w[i])
    );
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (clr) begin
      count_nxt = '0;
    end else if (ins_ok && !full) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_r     <= ins_ok | pop_ok | clr;
      ev_r      <= ins_ok & full;
      og_r      <= pop_ok ? ent_w[0].grade : '0;
      os_r      <= pop_ok ? ent_w[0].seq : '0;
      cnt_out_r <= count_nxt;
    end
  end

  assign cnt_wide        = (CW + CNT_W)'(cnt_out_r);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.accepted = acc_r;
  assign out_ch.evicted  = ev_r;
  assign out_ch.out_grade    = og_r;
  assign out_ch.out_sequence = os_r;
  assign out_ch.count    = cnt_wide[CNT_W-1:0];

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_evict_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ev_r |-> acc_r)
    else $error("eviction without acceptance");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok && !full |=> count_r == $past(count_r) + 1'b1)
    else $error("insert into non-full list did not grow count");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> count_r == '0)
    else $error("clear left entries");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_ch.operation == OP_POP && count_r == '0 |=> !acc_r)
    else $error("pop of empty list accepted");

endmodule

FILE: test/graded_work_priority_queue_core_check.sv
// ----------------------------------------------------------------------------
// graded_work_priority_queue_core_check
// Watches the item channels and the register port of the graded work
// priority queue, keeps its own sorted copy of the list, works out the result
// item of every accepted input item and compares it with the block's output.
// ----------------------------------------------------------------------------
module graded_work_priority_queue_core_check
  import gwpq_pkg::*;
#(
  parameter int CAPACITY = 32
)
(
  input  logic        clk,
  input  logic        rst_n,
  gwpq_in_if          in_ch,
  gwpq_out_if         out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatch_total,
  output int          due_total
);

  localparam logic [2:0] GRADE_LIMIT_ADDR = {REG_MAX_GRADE, 2'b00};

  typedef struct packed {
    logic               accepted;
    logic               evicted;
    logic [GRADE_W-1:0] grade;
    logic [SEQ_W-1:0]   seq;
    logic [CNT_W-1:0]   count;
  } outcome_t;

  logic [GRADE_W-1:0] grade_limit;
  entry_t             held [CAPACITY];
  int                 held_n;
  outcome_t           results_due [$];
  int                 shown;

  // new entry passes a held one only on a strict win
  function automatic bit outranks(entry_t cand, entry_t seat);
    int lead_gap;
    if (cand.grade != seat.grade) return cand.grade < seat.grade;
    lead_gap = int'(seat.seq[31:24]) - int'(cand.seq[31:24]);
    if (lead_gap != 0) begin
      // far apart first bytes have wrapped round, so the order flips
      if (lead_gap > WRAP_LIMIT || lead_gap < -WRAP_LIMIT) return lead_gap < 0;
      return lead_gap > 0;
    end
    return cand.seq[23:0] < seat.seq[23:0];
  endfunction

  // apply one item to the shadow list and return its result
  function automatic outcome_t apply_item(logic [1:0] op, logic [GRADE_W-1:0] g,
                                          logic [SEQ_W-1:0] s);
    outcome_t res;
    entry_t   fresh;
    int       pos;
    int       i;
    bit       full;
    res   = '0;
    fresh = '{grade: g, seq: s};
    case (op)
      OP_INSERT: begin
        if (g <= grade_limit) begin
          full = (held_n >= CAPACITY);
          pos  = held_n;
          // walk up from the tail, shifting every entry the new one beats
          while (pos > 0 && outranks(fresh, held[pos-1])) begin
            if (pos < CAPACITY) held[pos] = held[pos-1];
            pos--;
          end
          // landing past the last slot means the new entry is the worst
          if (pos < CAPACITY) begin
            held[pos]    = fresh;
            res.accepted = 1'b1;
            if (full) res.evicted = 1'b1;
            else held_n++;
          end
        end
      end
      OP_POP: begin
        if (held_n > 0) begin
          res.grade = held[0].grade;
          res.seq   = held[0].seq;
          held_n--;
          for (i = 0; i < held_n; i++) held[i] = held[i+1];
          res.accepted = 1'b1;
        end
      end
      OP_CLEAR: begin
        held_n       = 0;
        res.accepted = 1'b1;
      end
      default: ;
    endcase
    res.count = CNT_W'(held_n);
    return res;
  endfunction

  // predict on input items, compare on result items
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (!rst_n) begin
      grade_limit = MAX_GRADE_RST;
      held_n      = 0;
      results_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == GRADE_LIMIT_ADDR) begin
        grade_limit = cfg_pwdata[GRADE_W-1:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        results_due.push_back(apply_item(in_ch.operation, in_ch.in_grade,
                                         in_ch.in_sequence));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{accepted: out_ch.accepted, evicted: out_ch.evicted,
                grade: out_ch.out_grade, seq: out_ch.out_sequence,
                count: out_ch.count};
        if (results_due.size() == 0) begin
          if (shown < 10) begin
            $display("unexpected result item: acc=%0d ev=%0d grade=%0h seq=%08h count=%0d",
                     got.accepted, got.evicted, got.grade, got.seq, got.count);
          end
          shown++;
          mismatch_total <= mismatch_total + 1;
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            if (shown < 10) begin
              $display("mismatch: expected acc=%0d ev=%0d grade=%0h seq=%08h count=%0d",
                       want.accepted, want.evicted, want.grade, want.seq, want.count);
              $display("          actual   acc=%0d ev=%0d grade=%0h seq=%08h count=%0d",
                       got.accepted, got.evicted, got.grade, got.seq, got.count);
            end
            shown++;
            mismatch_total <= mismatch_total + 1;
          end
        end
      end
    end
    due_total <= results_due.size();
  end

endmodule

FILE: test/graded_work_priority_queue_core_test.sv
// ----------------------------------------------------------------------------
// graded_work_priority_queue_core_test
// Drives the graded work priority queue with a directed opening of edge
// grades, wrap-round sequences, ties, empty pops and clears, then phases of
// random items under several grade limits, with random gaps on both channels.
// ----------------------------------------------------------------------------
module graded_work_priority_queue_core_test;
  import gwpq_pkg::*;

  localparam int         CAPACITY        = 32;
  localparam int         PHASES          = 8;
  localparam int         ITEMS_PER_PHASE = 150;
  localparam int         STALL_LIMIT     = 2000;
  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam logic [2:0] GRADE_LIMIT_ADDR = {REG_MAX_GRADE, 2'b00};

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          mismatch_total;
  int          due_total;
  int          stall_cycles;
  bit          calm;

  gwpq_in_if  in_ch ();
  gwpq_out_if out_ch ();

  graded_work_priority_queue_core #(.CAPACITY(CAPACITY)) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  graded_work_priority_queue_core_check #(.CAPACITY(CAPACITY)) i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .mismatch_total (mismatch_total),
    .due_total      (due_total)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // offer one item, with random gaps ahead of it, and wait for it to be taken
  task automatic send_item(input logic [1:0] op, input logic [7:0] g,
                           input logic [31:0] s);
    while (!calm && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.in_grade    <= g;
    in_ch.in_sequence <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop offering and wait until every result item has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_total != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // write the grade limit once the block is idle
  task automatic set_grade_limit(input logic [7:0] limit);
    drain();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= GRADE_LIMIT_ADDR;
    cfg_pwdata  <= {24'($urandom), limit};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // stimulus
  initial begin
    int          ph;
    int          n;
    int          gi;
    int          roll;
    int          ins_pct;
    int          pop_pct;
    int          clr_pct;
    logic [1:0]  op;
    logic [7:0]  limit;
    logic [7:0]  g;
    logic [7:0]  centre;
    logic [7:0]  lead;
    logic [31:0] s;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_INSERT;
    in_ch.in_grade    <= '0;
    in_ch.in_sequence <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    calm              = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, unused code, grade limit edges
    send_item(OP_POP,    8'd0,   32'h0);
    send_item(OP_UNUSED, 8'hFF,  32'hFFFF_FFFF);
    send_item(OP_CLEAR,  8'd0,   32'h0);
    send_item(OP_INSERT, 8'd0,   32'h0000_0000);
    send_item(OP_INSERT, 8'd122, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 8'd123, 32'h1234_5678);
    send_item(OP_INSERT, 8'd255, 32'h0000_0001);
    // equal grades: near first bytes, wrapped first bytes, low bytes, ties
    send_item(OP_INSERT, 8'd50,  32'h0A00_0005);
    send_item(OP_INSERT, 8'd50,  32'h0F00_0005);
    send_item(OP_INSERT, 8'd50,  32'h2000_0005);
    send_item(OP_INSERT, 8'd50,  32'h0A00_0001);
    send_item(OP_INSERT, 8'd50,  32'h0A00_0005);
    send_item(OP_INSERT, 8'd50,  32'h00FF_FFFF);
    send_item(OP_INSERT, 8'd50,  32'hFF00_0000);
    repeat (5) send_item(OP_POP, 8'd0, 32'h0);
    send_item(OP_CLEAR,  8'd0,   32'h0);
    send_item(OP_POP,    8'd0,   32'h0);
    // widest and narrowest grade limits
    set_grade_limit(8'd255);
    send_item(OP_INSERT, 8'd255, 32'hA5A5_5A5A);
    set_grade_limit(8'd0);
    send_item(OP_INSERT, 8'd1,   32'h0000_0002);
    send_item(OP_INSERT, 8'd0,   32'h0000_0002);
    send_item(OP_POP,    8'd0,   32'h0);

    // random phases, each under its own grade limit and operation mix
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       limit = 8'd255;
        1:       limit = 8'd0;
        2:       limit = 8'd122;
        3:       limit = 8'd1;
        4:       limit = 8'd254;
        7:       limit = 8'd122;
        default: limit = 8'($urandom);
      endcase
      set_grade_limit(limit);
      calm = (ph == 3);
      case (ph)
        0:       centre = 8'd250;
        1:       centre = 8'd3;
        default: centre = 8'($urandom);
      endcase
      case (ph % 3)
        0: begin
          ins_pct = 84; pop_pct = 14; clr_pct = 1;
        end
        1: begin
          ins_pct = 50; pop_pct = 46; clr_pct = 2;
        end
        default: begin
          ins_pct = 30; pop_pct = 64; clr_pct = 3;
        end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if (roll < ins_pct) op = OP_INSERT;
        else if (roll < ins_pct + pop_pct) op = OP_POP;
        else if (roll < ins_pct + pop_pct + clr_pct) op = OP_CLEAR;
        else op = OP_UNUSED;
        // grades cluster round the limit and at the very top of the order
        roll = $urandom_range(99);
        if (roll < 15) g = 8'($urandom);
        else if (roll < 55) begin
          gi = int'(limit) - 2 + int'($urandom_range(3));
          g  = (gi < 0) ? 8'd0 : (gi > 255) ? 8'd255 : 8'(gi);
        end else g = 8'($urandom_range(3));
        // first bytes spread either side of the wrap distance
        lead = centre + 8'($urandom_range(24)) - 8'd12;
        roll = $urandom_range(99);
        if (roll < 25) s = $urandom;
        else if (roll < 60) s = {lead, 24'($urandom_range(3))};
        else s = {lead, 24'($urandom)};
        send_item(op, g, s);
      end
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_total == 0 && due_total == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
